// ===== sv/smof_pkg.sv =====
`timescale 1ns / 1ps

package smof_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int DMED_W    = 9;
  localparam int FLAG_W    = 32;
  localparam int CFG_W     = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd5;
  localparam logic [FLAG_W-1:0] FLAG_MAX = '1;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_WSTART = 9'b000000100,
    ST_WALK   = 9'b000001000,
    ST_DRD    = 9'b000010000,
    ST_DWR    = 9'b000100000,
    ST_IRD    = 9'b001000000,
    ST_IWR    = 9'b010000000,
    ST_RES    = 9'b100000000
  } smof_state_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } smof_ctl_t;

endpackage

// ===== sv/smof_if.sv =====
`timescale 1ns / 1ps

interface smof_in_if;
  import smof_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface smof_out_if;
  import smof_pkg::*;
  logic              valid;
  logic              ready;
  logic              window_ready;
  logic              outlier_flag;
  logic [DMED_W-1:0] doubled_median;
  logic [FLAG_W-1:0] flag_total;
  modport source (output valid, output window_ready, output outlier_flag,
                  output doubled_median, output flag_total, input ready);
  modport sink   (input valid, input window_ready, input outlier_flag,
                  input doubled_median, input flag_total, output ready);
endinterface

// ===== sv/smof_front.sv =====
`timescale 1ns / 1ps

module smof_front #(
  parameter int VALUE_BINS = 201,
  parameter int BIN_W      = $clog2(VALUE_BINS)
) (
  input  logic               clk,
  input  logic               rst_n,
  smof_in_if.sink            in_if,
  input  smof_pkg::smof_ctl_t ctl,
  output logic               q_valid,
  output logic [BIN_W-1:0]   q_data
);
  import smof_pkg::*;

  logic [BIN_W-1:0] q_mem_r [2];
  logic             wr_idx_r, rd_idx_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [BIN_W-1:0] sat;
  logic             push, pop;

  always_comb begin
    if (32'(in_if.sample_value) >= 32'(VALUE_BINS)) begin
      sat = BIN_W'(VALUE_BINS - 1);
    end else begin
      sat = BIN_W'(in_if.sample_value);
    end
  end

  assign in_if.ready = (cnt_r != 2'd2) && !ctl.clearing;
  assign push    = in_if.valid && in_if.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = ctl.pop && q_valid;
  assign q_data  = q_mem_r[rd_idx_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_idx_r <= !wr_idx_r;
      if (pop)  rd_idx_r <= !rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_idx_r] <= sat;
  end

endmodule

// ===== sv/smof_back.sv =====
`timescale 1ns / 1ps

module smof_back #(
  parameter int VALUE_BINS = 201,
  parameter int MAX_WINDOW = 1024,
  parameter int BIN_W      = $clog2(VALUE_BINS),
  parameter int PTR_W      = $clog2(MAX_WINDOW),
  parameter int CNT_W      = $clog2(MAX_WINDOW + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [smof_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      q_valid,
  input  logic [BIN_W-1:0]          q_data,
  output smof_pkg::smof_ctl_t       ctl,
  smof_out_if.source                out_if
);
  import smof_pkg::*;

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(VALUE_BINS - 1);

  smof_state_t state_r, state_nxt;

  logic [CNT_W-1:0] hist [VALUE_BINS];
  logic [CNT_W-1:0] hist_rd_r;
  logic             h_we;
  logic [BIN_W-1:0] h_wa, h_ra;
  logic [CNT_W-1:0] h_wd;

  logic [BIN_W-1:0] dl [MAX_WINDOW];
  logic [BIN_W-1:0] dl_rd_r;
  logic             dl_re, dl_we;

  logic [CFG_W-1:0] wlen_r;
  logic [BIN_W-1:0] clr_r, bin_r, lo_r, hi_r, s_r;
  logic [CNT_W-1:0] acc_r, fill_r, w_eff, half, rank_lo, acc_sum, ptr_inc;
  logic             found_lo_r, full_r;
  logic [PTR_W-1:0] ptr_r;
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic [31:0]      dm32;
  logic             flag, load;

  logic              ov_r, ow_r, of_r;
  logic [DMED_W-1:0] od_r;
  logic [FLAG_W-1:0] ot_r;

  always_comb begin
    if (wlen_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(wlen_r) > 32'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(wlen_r);
    end
  end

  assign half    = w_eff >> 1;
  assign rank_lo = w_eff[0] ? half : half - CNT_W'(1);
  assign acc_sum = acc_r + hist_rd_r;
  assign ptr_inc = CNT_W'(ptr_r) + CNT_W'(1);
  assign dm32    = 32'(lo_r) + 32'(hi_r);
  assign flag    = full_r && (32'(s_r) >= dm32);
  assign load    = (state_r == ST_RES) && (!ov_r || out_if.ready);

  always_comb begin
    flags_nxt = flags_r;
    if (flag && flags_r != FLAG_MAX) flags_nxt = flags_r + FLAG_W'(1);
  end

  assign ctl.clearing = (state_r == ST_CLEAR);
  assign ctl.pop      = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    h_we  = 1'b0;
    h_wa  = clr_r;
    h_wd  = '0;
    h_ra  = '0;
    dl_re = 1'b0;
    dl_we = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        h_we = 1'b1;
        if (clr_r == LAST_BIN) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          dl_re     = 1'b1;
          state_nxt = (fill_r >= w_eff) ? ST_WSTART : ST_IRD;
        end
      end
      ST_WSTART: begin
        h_ra      = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        h_ra = (bin_r == LAST_BIN) ? bin_r : bin_r + BIN_W'(1);
        if (acc_sum > half || bin_r == LAST_BIN) state_nxt = ST_DRD;
      end
      ST_DRD: begin
        h_ra      = dl_rd_r;
        state_nxt = ST_DWR;
      end
      ST_DWR: begin
        h_wa      = dl_rd_r;
        h_wd      = hist_rd_r - CNT_W'(1);
        h_we      = (hist_rd_r != '0);
        state_nxt = ST_IRD;
      end
      ST_IRD: begin
        h_ra      = s_r;
        state_nxt = ST_IWR;
      end
      ST_IWR: begin
        h_wa      = s_r;
        h_wd      = hist_rd_r + CNT_W'(1);
        h_we      = 1'b1;
        dl_we     = 1'b1;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) hist[h_wa] <= h_wd;
    hist_rd_r <= hist[h_ra];
  end

  always_ff @(posedge clk) begin
    if (dl_we) dl[ptr_r] <= s_r;
    if (dl_re) dl_rd_r <= dl[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      wlen_r  <= CFG_RESET;
      fill_r  <= '0;
      ptr_r   <= '0;
      flags_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        wlen_r  <= cfg_wdata;
        state_r <= ST_CLEAR;
        clr_r   <= '0;
        fill_r  <= '0;
        ptr_r   <= '0;
      end else begin
        state_r <= state_nxt;
        if (state_r == ST_CLEAR) clr_r <= clr_r + BIN_W'(1);
        if (state_r == ST_IDLE && q_valid && fill_r < w_eff) fill_r <= fill_r + CNT_W'(1);
        if (state_r == ST_IWR) ptr_r <= (ptr_inc >= w_eff) ? '0 : PTR_W'(ptr_inc);
      end
      if (load) begin
        flags_r <= flags_nxt;
        ov_r    <= 1'b1;
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        s_r    <= q_data;
        full_r <= (fill_r >= w_eff);
      end
      ST_WSTART: begin
        bin_r      <= '0;
        acc_r      <= '0;
        found_lo_r <= 1'b0;
        lo_r       <= LAST_BIN;
        hi_r       <= LAST_BIN;
      end
      ST_WALK: begin
        acc_r <= acc_sum;
        bin_r <= bin_r + BIN_W'(1);
        if (!found_lo_r && acc_sum > rank_lo) begin
          lo_r       <= bin_r;
          found_lo_r <= 1'b1;
        end
        if (acc_sum > half) hi_r <= bin_r;
      end
      default: ;
    endcase
    if (load) begin
      ow_r <= full_r;
      of_r <= flag;
      od_r <= full_r ? dm32[DMED_W-1:0] : '0;
      ot_r <= flags_nxt;
    end
  end

  assign out_if.valid          = ov_r;
  assign out_if.window_ready   = ow_r;
  assign out_if.outlier_flag   = of_r;
  assign out_if.doubled_median = od_r;
  assign out_if.flag_total     = ot_r;

endmodule

// ===== sv/sliding_median_outlier_flag.sv =====
// channel | dir | handshake            | payload
// in_if   | in  | valid/ready          | sample_value[7:0]
// out_if  | out | valid/ready          | window_ready, outlier_flag,
//         |     |                      | doubled_median[8:0], flag_total[31:0]
// cfg     | in  | cfg_we, no wait      | cfg_wdata[10:0] window_length
//
// Full window: the per-item time is set by the histogram walk (one bin per
// cycle through the registered histogram read port).
// Window filling: each item skips the walk. A two-entry queue decouples intake.
// Reset and each cfg write start a clearing pass over every histogram bin;
// in_if.ready is low for its duration.
// A result waiting on out_if.ready stalls the back end; intake continues until the queue is full.
`timescale 1ns / 1ps

module sliding_median_outlier_flag #(
  parameter int VALUE_BINS = 201,
  parameter int MAX_WINDOW = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [smof_pkg::CFG_W-1:0] cfg_wdata,
  smof_in_if.sink                    in_if,
  smof_out_if.source                 out_if
);
  import smof_pkg::*;

  localparam int BIN_W = $clog2(VALUE_BINS);

  smof_ctl_t        ctl;
  logic             q_valid;
  logic [BIN_W-1:0] q_data;

  smof_front #(.VALUE_BINS(VALUE_BINS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .ctl(ctl),
    .q_valid(q_valid), .q_data(q_data)
  );

  smof_back #(.VALUE_BINS(VALUE_BINS), .MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_data(q_data), .ctl(ctl), .out_if(out_if)
  );

endmodule

// ===== sv/smof_checker.sv =====
`timescale 1ns / 1ps

module smof_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        window_ready,
  input logic        outlier_flag,
  input logic [8:0]  doubled_median,
  input logic [31:0] flag_total
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(flag_total) &&
    $stable(doubled_median))
    else $error("result changed while stalled");

  a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !window_ready |-> !outlier_flag && doubled_median == 9'd0)
    else $error("flag or median without full window");

  a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && outlier_flag |-> flag_total != 32'd0)
    else $error("flagged item with zero total");

  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("intake open during clearing pass");

endmodule

bind sliding_median_outlier_flag smof_checker u_smof_checker (
  .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .window_ready(out_if.window_ready), .outlier_flag(out_if.outlier_flag),
  .doubled_median(out_if.doubled_median), .flag_total(out_if.flag_total)
);

// ===== tb/sliding_median_outlier_flag_tb.sv =====
`timescale 1ns / 1ps

module sliding_median_outlier_flag_tb;
  import smof_pkg::*;

  localparam int BINS = 201;
  localparam int MAXW = 1024;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic              wready;
    logic              flag;
    logic [DMED_W-1:0] dmed;
    logic [FLAG_W-1:0] total;
  } verdict_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    bit                  typed;
    verdict_t            want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  smof_in_if  in_if();
  smof_out_if out_if();

  sliding_median_outlier_flag dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [SAMPLE_W-1:0] hist_line [MAXW];
  int unsigned hist_bins [BINS];
  int unsigned fill, wptr, wlen;
  logic [FLAG_W-1:0] flags;
  verdict_t pending_verdicts [$];
  int errors = 0;
  int cycles = 0;

  function automatic int unsigned eff_window();
    if (wlen == 0) return 1;
    if (wlen > MAXW) return MAXW;
    return wlen;
  endfunction

  function automatic int unsigned rank_value(int unsigned rank);
    int unsigned acc;
    acc = 0;
    for (int b = 0; b < BINS; b++) begin
      acc += hist_bins[b];
      if (acc > rank) return b;
    end
    return BINS - 1;
  endfunction

  task automatic empty_window();
    foreach (hist_bins[i]) hist_bins[i] = 0;
    fill = 0;
    wptr = 0;
  endtask

  function automatic verdict_t median_verdict(logic [SAMPLE_W-1:0] raw);
    verdict_t v;
    int unsigned w, s, dm, old;
    v = '0;
    w = eff_window();
    s = (raw >= BINS) ? BINS - 1 : 32'(raw);
    if (wptr >= w) wptr = 0;
    if (fill >= w) begin
      v.wready = 1'b1;
      if (w % 2) dm = 2 * rank_value(w / 2);
      else dm = rank_value(w / 2 - 1) + rank_value(w / 2);
      v.dmed = dm[DMED_W-1:0];
      if (s >= dm) begin
        v.flag = 1'b1;
        if (flags != FLAG_MAX) flags++;
      end
      old = 32'(hist_line[wptr]);
      if (old < BINS && hist_bins[old] > 0) hist_bins[old]--;
    end else begin
      fill++;
    end
    hist_line[wptr] = SAMPLE_W'(s);
    hist_bins[s]++;
    wptr++;
    if (wptr >= w) wptr = 0;
    v.total = flags;
    return v;
  endfunction

  task automatic send_sample(logic [SAMPLE_W-1:0] s, bit typed, verdict_t want);
    verdict_t v;
    int unsigned gap;
    gap = $urandom_range(0, 12);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.sample_value <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    v = median_verdict(s);
    if (typed && v != want) begin
      $display("%0t table row mismatch expected %h actual %h", $time, want, v);
      errors++;
    end
    pending_verdicts = {pending_verdicts, v};
    @(negedge clk);
  endtask

  task automatic set_window(logic [CFG_W-1:0] w);
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (BINS + 20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
    wlen = w;
    empty_window();
  endtask

  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.window_ready, out_if.outlier_flag, out_if.doubled_median,
             out_if.flag_total};
      if (pending_verdicts.size() == 0) begin
        $display("%0t unexpected item actual %h", $time, got);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.wready !== want.wready) begin
          $display("%0t window_ready expected %0d actual %0d", $time, want.wready, got.wready);
          errors++;
        end
        if (got.flag !== want.flag) begin
          $display("%0t outlier_flag expected %0d actual %0d", $time, want.flag, got.flag);
          errors++;
        end
        if (got.dmed !== want.dmed) begin
          $display("%0t doubled_median expected %0d actual %0d", $time, want.dmed, got.dmed);
          errors++;
        end
        if (got.total !== want.total) begin
          $display("%0t flag_total expected %0d actual %0d", $time, want.total, got.total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  row_t rows [] = '{
    '{8'd0,   1'b1, '{1'b0, 1'b0, 9'd0, 32'd0}},
    '{8'd10,  1'b1, '{1'b0, 1'b0, 9'd0, 32'd0}},
    '{8'd20,  1'b1, '{1'b0, 1'b0, 9'd0, 32'd0}},
    '{8'd30,  1'b1, '{1'b0, 1'b0, 9'd0, 32'd0}},
    '{8'd40,  1'b1, '{1'b0, 1'b0, 9'd0, 32'd0}},
    '{8'd40,  1'b1, '{1'b1, 1'b1, 9'd40, 32'd1}},
    '{8'd79,  1'b0, '0},
    '{8'd200, 1'b0, '0},
    '{8'd255, 1'b0, '0},
    '{8'd128, 1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd201, 1'b0, '0},
    '{8'd1,   1'b0, '0}
  };

  int unsigned wsel [] = '{1, 2, 0, 3, 2047, 4, 7, 16, 150, 6};

  initial begin
    in_if.valid = 1'b0;
    in_if.sample_value = '0;
    wlen = CFG_RESET;
    flags = '0;
    empty_window();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].typed, rows[i].want);
    foreach (wsel[k]) begin
      int n;
      set_window(CFG_W'(wsel[k]));
      if (eff_window() > 256) n = 30;
      else if (eff_window() > 40) n = int'(eff_window()) + 40;
      else n = 60;
      for (int i = 0; i < n; i++) begin
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 3))
          0: s = SAMPLE_W'($urandom);
          1: s = SAMPLE_W'($urandom_range(0, 30));
          2: s = SAMPLE_W'($urandom_range(60, 200));
          default: s = SAMPLE_W'($urandom_range(0, 255));
        endcase
        send_sample(s, 1'b0, '0);
      end
    end
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (BINS + 20) @(negedge clk);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
